[sv/wbr_pkg.sv]
// Shared constants, register codes and item types for the windowed baseline RMS block.
`default_nettype none
package wbr_pkg;

    // Spectrum geometry
    localparam int MAX_CHANNELS = 2048;
    localparam int CH_W         = $clog2(MAX_CHANNELS + 1);

    // Configuration port
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CMP_W     = (CH_W > CFG_W) ? CH_W : CFG_W;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_END    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_END   = 2'd3;

    localparam logic [CFG_W-1:0] FIRST_START_RST  = 12'd100;
    localparam logic [CFG_W-1:0] FIRST_END_RST    = 12'd400;
    localparam logic [CFG_W-1:0] SECOND_START_RST = 12'd1648;
    localparam logic [CFG_W-1:0] SECOND_END_RST   = 12'd1948;

    // Datapath widths
    localparam int SAMPLE_W = 24;
    localparam int MAG_W    = 24;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = 60;
    localparam int CNT_W    = 13;
    localparam int RMS_W    = 24;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int STEP_W   = $clog2(SUM_W);

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_channel;
    } in_item_t;

    typedef struct packed {
        logic [RMS_W-1:0] rms;
        logic             rms_valid;
        logic [CNT_W-1:0] summed_count;
    } out_item_t;

    // One finished spectrum: accumulated squares and term count
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } job_t;

    // Queue status seen by its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage
`default_nettype wire

[sv/wbr_front.sv]
// Front end: window registers, channel counting, squaring and accumulation.
`default_nettype none
module wbr_front
    import wbr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    input  wire queue_status_t        q_status,
    output logic                      q_push,
    output job_t                      q_push_data
);

    logic [CFG_W-1:0] fw_start_reg, fw_end_reg, sw_start_reg, sw_end_reg;
    logic [CH_W-1:0]  pos_reg, pos_next;

    // stage A: magnitude and window hits
    logic             a_valid_reg;
    logic [MAG_W-1:0] a_mag_reg, a_mag_next;
    logic [1:0]       a_hits_reg, a_hits_next;
    logic             a_last_reg;

    // stage B: square
    logic             b_valid_reg;
    logic [SQ_W-1:0]  b_sq_reg;
    logic [1:0]       b_hits_reg;
    logic             b_last_reg;

    logic [SUM_W-1:0] sum_reg, sum_new;
    logic [CNT_W-1:0] cnt_reg, cnt_new;

    logic             adv, accept, in_range, hit1, hit2;
    logic [CMP_W-1:0] pos_x;
    logic [MAG_W-1:0] raw;
    logic [SQ_W:0]    add_val;
    logic [SUM_W:0]   sum_wide;
    logic [CNT_W:0]   cnt_wide;

    // whole pipe holds only when a spectrum end meets a full queue
    assign adv     = !(b_valid_reg && b_last_reg && q_status.full);
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_start_reg <= FIRST_START_RST;
            fw_end_reg   <= FIRST_END_RST;
            sw_start_reg <= SECOND_START_RST;
            sw_end_reg   <= SECOND_END_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FIRST_START:  fw_start_reg <= cfg_wdata;
                REG_FIRST_END:    fw_end_reg   <= cfg_wdata;
                REG_SECOND_START: sw_start_reg <= cfg_wdata;
                REG_SECOND_END:   sw_end_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        pos_x    = CMP_W'(pos_reg);
        in_range = pos_reg < CH_W'(MAX_CHANNELS);
        hit1     = in_range && (pos_x >= CMP_W'(fw_start_reg)) && (pos_x < CMP_W'(fw_end_reg));
        hit2     = in_range && (pos_x >= CMP_W'(sw_start_reg)) && (pos_x < CMP_W'(sw_end_reg));
        a_hits_next = {hit1 & hit2, hit1 ^ hit2};
        raw        = MAG_W'(unsigned'(s_data.sample));
        a_mag_next = s_data.sample[SAMPLE_W-1] ? (~raw + MAG_W'(1)) : raw;
        if (s_data.last_channel) begin
            pos_next = '0;
        end else if (in_range) begin
            pos_next = pos_reg + CH_W'(1);
        end else begin
            pos_next = pos_reg;
        end
    end

    // two equal adds saturate the same as one double add
    always_comb begin
        case (b_hits_reg)
            2'd2:    add_val = {b_sq_reg, 1'b0};
            2'd1:    add_val = {1'b0, b_sq_reg};
            default: add_val = '0;
        endcase
        sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(add_val);
        sum_new  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        cnt_wide = {1'b0, cnt_reg} + (CNT_W+1)'(b_hits_reg);
        cnt_new  = cnt_wide[CNT_W] ? '1 : cnt_wide[CNT_W-1:0];
    end

    assign q_push            = adv && b_valid_reg && b_last_reg;
    assign q_push_data.sum   = sum_new;
    assign q_push_data.count = cnt_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            if (accept) begin
                pos_reg <= pos_next;
            end
            if (b_valid_reg) begin
                if (b_last_reg) begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    sum_reg <= sum_new;
                    cnt_reg <= cnt_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_mag_reg  <= a_mag_next;
            a_hits_reg <= a_hits_next;
            a_last_reg <= s_data.last_channel;
            b_sq_reg   <= a_mag_reg * a_mag_reg;
            b_hits_reg <= a_hits_reg;
            b_last_reg <= a_last_reg;
        end
    end

endmodule
`default_nettype wire

[sv/wbr_queue.sv]
// Small job queue between the accumulating front and the divide/root back end.
`default_nettype none
module wbr_queue
    import wbr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire job_t    push_data,
    input  wire logic    pop,
    output job_t         pop_data,
    output queue_status_t status
);

    job_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    fill_reg;

    assign status.full  = fill_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign status.empty = fill_reg == '0;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

[sv/wbr_back.sv]
// Back end: restoring divide by n-1, digit-by-digit square root, saturation, result register.
`default_nettype none
module wbr_back
    import wbr_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire queue_status_t q_status,
    input  wire job_t          q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output out_item_t          m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [SUM_W-1:0]  work_reg, work_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ROOT_W+1:0] srem_reg, srem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    out_item_t         out_reg, out_next;

    logic [CNT_W:0]    div_shift;
    logic              div_ge;
    logic [ROOT_W+3:0] sq_shift, sq_trial;
    logic              sq_ge;

    assign q_pop   = (state_reg == ST_IDLE) && !q_status.empty;
    assign m_valid = state_reg == ST_DONE;
    assign m_data  = out_reg;

    always_comb begin
        div_shift = {rem_reg[CNT_W-1:0], work_reg[SUM_W-1]};
        div_ge    = div_shift >= {1'b0, div_reg};
        sq_shift  = {srem_reg, work_reg[SUM_W-1 -: 2]};
        sq_trial  = (ROOT_W+4)'({root_reg, 2'b01});
        sq_ge     = sq_shift >= sq_trial;
    end

    always_comb begin
        state_next = state_reg;
        work_next  = work_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        step_next  = step_reg;
        out_next   = out_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    out_next.summed_count = q_data.count;
                    if (q_data.count < CNT_W'(2)) begin
                        out_next.rms       = '0;
                        out_next.rms_valid = 1'b0;
                        state_next         = ST_DONE;
                    end else begin
                        work_next  = q_data.sum;
                        div_next   = q_data.count - CNT_W'(1);
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next  = div_ge ? (div_shift - {1'b0, div_reg}) : div_shift;
                work_next = {work_reg[SUM_W-2:0], div_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    step_next  = '0;
                    root_next  = '0;
                    srem_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                srem_next = sq_ge ? (ROOT_W+2)'(sq_shift - sq_trial)
                                  : (ROOT_W+2)'(sq_shift);
                root_next = {root_reg[ROOT_W-2:0], sq_ge};
                work_next = {work_reg[SUM_W-3:0], 2'b00};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_W - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                out_next.rms       = (|root_reg[ROOT_W-1:RMS_W]) ? '1 : root_reg[RMS_W-1:0];
                out_next.rms_valid = 1'b1;
                state_next         = ST_DONE;
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        srem_reg <= srem_next;
        step_reg <= step_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.rms_valid |-> m_data.rms == '0)
        else $error("invalid result carries nonzero rms");

    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rms_valid |-> m_data.summed_count >= CNT_W'(2))
        else $error("valid result with fewer than two terms");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> div_reg != '0)
        else $error("divide started with zero divisor");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < {1'b0, div_reg})
        else $error("division remainder out of range");
`endif

endmodule
`default_nettype wire

[sv/windowed_baseline_rms.sv]
// Top level of the windowed baseline RMS block: front end, job queue, divide/root back end.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------------------
//  input   | s_valid s_ready s_data         | one spectrum channel sample per item
//  result  | m_valid m_ready m_data         | one rms item per spectrum (on last_channel)
//  config  | cfg_we cfg_index cfg_wdata     | window start/end writes, no read-back
//
//  Samples stream in at one item per cycle while s_ready is high; the front end squares
//  and accumulates in a two-stage pipe. Each spectrum end then runs through the back end
//  (60 restoring divide steps, 30 square root steps) and waits there while m_ready stays
//  low; a spectrum with fewer than two terms goes straight from the pop to the result.
//  Two finished spectra can wait in the job queue while the back end works on another;
//  s_ready drops when the next spectrum end reaches the accumulator with the queue full.
//  Reset (aresetn, synchronous) restores the window defaults and clears all counters.
`default_nettype none
module windowed_baseline_rms
    import wbr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration writes
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // sample items
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    // result items
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data
);

    queue_status_t q_status;
    logic          q_push, q_pop;
    job_t          q_push_data, q_pop_data;

    // windows, channel count and sum of squares
    wbr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    // decouples the streaming side from the slow per-spectrum math
    wbr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    // sqrt(sum / (n - 1)) with saturation, held until taken
    wbr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire
